[rtl/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int IDX_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int STRIDE_W  = 13;
    localparam int ADDR_W    = 64;
    localparam int OFFSET_W  = IDX_W + STRIDE_W;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FRESH = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADER_VISIBLE = 3'd4;

    localparam logic [COUNT_W-1:0]  RST_SLOT_COUNT  = 11'd1024;
    localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE = 13'd32;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECIDE = 3'd1,
        S_READ   = 3'd2,
        S_MUL    = 3'd3,
        S_ADD    = 3'd4
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic ram_capture;
        logic mul;
        logic finish;
    } dsa_ctrl_t;

    typedef struct packed {
        logic take_fifo;
        logic out_ready;
    } dsa_stat_t;

endpackage

[rtl/dsa_ram.sv]
// ----------------------------------------------------------------------------
// dsa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
    parameter int DATA_W = 10,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dsa_ctrl.sv]
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: accept, decide, optional free-list read, multiply, add and emit.
// ----------------------------------------------------------------------------
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dsa_stat_t stat,
    output dsa_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next  = stat.take_fifo ? S_READ : S_MUL;
            end
            S_READ:
            begin
                ctrl.ram_capture = 1'b1;
                state_next       = S_MUL;
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (stat.out_ready)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/dsa_datapath.sv]
// ----------------------------------------------------------------------------
// dsa_datapath
// Registers, bump counter, free-list pointers, handle arithmetic, output stage.
// ----------------------------------------------------------------------------
module dsa_datapath
    import dsa_pkg::*;
#(
    parameter int SLOT_CAPACITY = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      command,
    input  logic [IDX_W-1:0]      free_index,
    input  dsa_ctrl_t             ctrl,
    output dsa_stat_t             stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      slot_index,
    output logic [ADDR_W-1:0]     cpu_handle,
    output logic [ADDR_W-1:0]     gpu_handle,
    output logic [STATUS_W-1:0]   status
);

    localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
    localparam int PTR_W = $clog2(SLOT_CAPACITY);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(SLOT_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_FILL = CNT_W'(SLOT_CAPACITY);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOT_CAPACITY - 1);

    logic [COUNT_W-1:0]  slot_count_reg;
    logic [STRIDE_W-1:0] slot_stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                shader_visible_reg;

    cmd_t                cmd_reg;
    logic [IDX_W-1:0]    free_index_reg;

    logic [CNT_W-1:0]    next_fresh_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    fill_reg;

    logic                got_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    slot_index_reg;
    logic [ADDR_W-1:0]   cpu_handle_reg;
    logic [ADDR_W-1:0]   gpu_handle_reg;
    logic [STATUS_W-1:0] status_out_reg;

    logic [CMP_W-1:0]    count_eff;
    logic [CMP_W-1:0]    fresh_cmp;
    logic [CMP_W-1:0]    free_cmp;
    logic                is_alloc;
    logic                take_fifo;
    logic                fresh_ok;
    logic                free_bad;
    logic                fifo_full;
    logic                fifo_push;
    logic [IDX_W-1:0]    ram_rdata;
    logic [ADDR_W-1:0]   offset_ext;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
        return (pos == PTR_LAST) ? '0 : pos + 1'b1;
    endfunction

    always_comb
    begin
        count_eff = (CMP_W'(slot_count_reg) > CAP_CMP) ? CAP_CMP : CMP_W'(slot_count_reg);
        fresh_cmp = CMP_W'(next_fresh_reg);
        free_cmp  = CMP_W'(free_index_reg);
        is_alloc  = (cmd_reg == CMD_ALLOC) || (cmd_reg == CMD_FRESH);
        take_fifo = (cmd_reg == CMD_ALLOC) && (fill_reg != '0);
        fresh_ok  = fresh_cmp < count_eff;
        free_bad  = free_cmp >= count_eff;
        fifo_full = fill_reg == CAP_FILL;
        fifo_push = ctrl.decide && (cmd_reg == CMD_FREE) && !free_bad && !fifo_full;
    end

    assign stat.take_fifo = take_fifo;
    assign stat.out_ready = !out_valid_reg || !out_stall;

    dsa_ram #(
        .DATA_W (IDX_W),
        .DEPTH  (SLOT_CAPACITY)
    ) u_free_ram (
        .clk   (clk),
        .we    (fifo_push),
        .waddr (tail_reg),
        .wdata (free_index_reg),
        .re    (ctrl.decide && take_fifo),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg     <= RST_SLOT_COUNT;
            slot_stride_reg    <= RST_SLOT_STRIDE;
            cpu_base_reg       <= '0;
            gpu_base_reg       <= '0;
            shader_visible_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[COUNT_W-1:0];
                CFG_SLOT_STRIDE:    slot_stride_reg    <= cfg_data[STRIDE_W-1:0];
                CFG_CPU_BASE:       cpu_base_reg       <= cfg_data;
                CFG_GPU_BASE:       gpu_base_reg       <= cfg_data;
                CFG_SHADER_VISIBLE: shader_visible_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_fresh_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
        end
        else if (ctrl.decide)
        begin
            case (cmd_reg)
                CMD_ALLOC, CMD_FRESH:
                begin
                    if (take_fifo)
                    begin
                        head_reg <= ring_next(head_reg);
                        fill_reg <= fill_reg - 1'b1;
                    end
                    else if (fresh_ok)
                    begin
                        next_fresh_reg <= next_fresh_reg + 1'b1;
                    end
                end
                CMD_FREE:
                begin
                    if (fifo_push)
                    begin
                        tail_reg <= ring_next(tail_reg);
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                CMD_RESET:
                begin
                    next_fresh_reg <= '0;
                    head_reg       <= '0;
                    tail_reg       <= '0;
                    fill_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg        <= cmd_t'(command);
            free_index_reg <= free_index;
        end
        if (ctrl.decide)
        begin
            got_reg    <= is_alloc && (take_fifo || fresh_ok);
            slot_reg   <= (is_alloc && !take_fifo && fresh_ok) ? fresh_cmp[IDX_W-1:0] : '0;
            if (is_alloc && !take_fifo && !fresh_ok)
            begin
                status_reg <= ST_EXHAUSTED;
            end
            else if ((cmd_reg == CMD_FREE) && free_bad)
            begin
                status_reg <= ST_BAD_FREE;
            end
            else if ((cmd_reg == CMD_FREE) && fifo_full)
            begin
                status_reg <= ST_LIST_FULL;
            end
            else
            begin
                status_reg <= ST_OK;
            end
        end
        if (ctrl.ram_capture)
        begin
            slot_reg <= ram_rdata;
        end
        if (ctrl.mul)
        begin
            offset_reg <= OFFSET_W'(slot_reg) * OFFSET_W'(slot_stride_reg);
        end
    end

    assign offset_ext = ADDR_W'(offset_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            slot_index_reg <= got_reg ? slot_reg : '0;
            cpu_handle_reg <= got_reg ? cpu_base_reg + offset_ext : '0;
            gpu_handle_reg <= (got_reg && shader_visible_reg) ? gpu_base_reg + offset_ext : '0;
            status_out_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = slot_index_reg;
    assign cpu_handle = cpu_handle_reg;
    assign gpu_handle = gpu_handle_reg;
    assign status     = status_out_reg;

endmodule

[rtl/descriptor_slot_allocator.sv]
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Hands out descriptor slot indices and their CPU and GPU handles.
//
// Requests enter on in_valid/in_stall with a command and a free index; each
// request gives exactly one result on out_valid/out_stall with the slot
// index, both handles and a status code. The sequencer holds one request at
// a time. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while no request is in flight, which the block does not
// enforce. A request goes through the decide, multiply and add states to
// the output register, with a read state after decide when an allocation
// reuses a free-list index: the free-list RAM has a registered read, and
// the handle path is a multiply stage then a 64-bit add stage.
// A finished result waits in the output register while the receiver stalls;
// the next request is accepted and worked meanwhile and holds in its add
// stage until the output register frees.
// Reset clears the bump counter, the free-list pointers and fill, loads the
// register defaults and drops any pending result; free-list RAM contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator
    import dsa_pkg::*;
#(
    parameter int SLOT_CAPACITY = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [IDX_W-1:0]      free_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      slot_index,
    output logic [ADDR_W-1:0]     cpu_handle,
    output logic [ADDR_W-1:0]     gpu_handle,
    output logic [STATUS_W-1:0]   status
);

    dsa_ctrl_t ctrl;
    dsa_stat_t stat;

    dsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    dsa_datapath #(
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .free_index (free_index),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_index (slot_index),
        .cpu_handle (cpu_handle),
        .gpu_handle (gpu_handle),
        .status     (status)
    );

endmodule
